### hw/rtl/erc_pkg.sv
// Shared types, thresholds and helpers for the exercise repetition counter.
`timescale 1ns / 1ps

package erc_pkg;

    // Field widths and defaults
    localparam int SAMPLE_W        = 16;
    localparam int TARGET_W        = 8;
    localparam int REPS_W          = 8;
    localparam int COUNT_BITS_DEF  = 8;
    localparam logic [TARGET_W-1:0] TARGET_RESET = 8'd10;

    // Exercise slots in counter and indicator vectors
    localparam logic [1:0] EX_SITUP  = 2'd0;
    localparam logic [1:0] EX_PUSHUP = 2'd1;
    localparam logic [1:0] EX_SQUAT  = 2'd2;
    localparam logic [1:0] EX_JUMP   = 2'd3;

    // Thresholds in milli-g, all inclusive
    localparam logic signed [SAMPLE_W-1:0] TH_POS_600  = 16'sd600;
    localparam logic signed [SAMPLE_W-1:0] TH_POS_900  = 16'sd900;
    localparam logic signed [SAMPLE_W-1:0] TH_POS_1200 = 16'sd1200;
    localparam logic signed [SAMPLE_W-1:0] TH_POS_1800 = 16'sd1800;
    localparam logic signed [SAMPLE_W-1:0] TH_ZERO     = 16'sd0;
    localparam logic signed [SAMPLE_W-1:0] TH_NEG_600  = -16'sd600;
    localparam logic signed [SAMPLE_W-1:0] TH_NEG_900  = -16'sd900;
    localparam logic signed [SAMPLE_W-1:0] TH_NEG_1200 = -16'sd1200;

    // Sit-up recogniser phase
    typedef enum logic [1:0] {
        SU_IDLE  = 2'b01,
        SU_ARMED = 2'b10
    } t_su_phase;

    // Three-threshold recogniser phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_FIRST  = 3'b010,
        PH_SECOND = 3'b100
    } t_phase;

    typedef struct packed {
        t_su_phase situp;
        t_phase    pushup;
        t_phase    squat;
        t_phase    jump;
    } t_phases;

    typedef struct packed {
        t_phase ph;
        logic   rep;
    } t_step;

    // Advance a three-threshold recogniser by at most one transition
    function automatic t_step three_phase(t_phase ph, logic first, logic second,
                                          logic third);
        t_step s;
        s.ph  = ph;
        s.rep = 1'b0;
        case (ph)
            PH_FIRST: begin
                if (second) s.ph = PH_SECOND;
            end
            PH_SECOND: begin
                if (third) begin
                    s.ph  = PH_IDLE;
                    s.rep = 1'b1;
                end
            end
            default: begin
                s.ph = first ? PH_FIRST : PH_IDLE;
            end
        endcase
        return s;
    endfunction

endpackage

### hw/rtl/erc_in_stage.sv
// Input register stage holding one accepted sample pair.
`timescale 1ns / 1ps

module erc_in_stage
    import erc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_accel_x,
    input  logic signed [SAMPLE_W-1:0] i_accel_z,
    input  logic                       i_advance,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_accel_x,
    output logic signed [SAMPLE_W-1:0] o_accel_z
);

    logic                       r_valid, n_valid;
    logic signed [SAMPLE_W-1:0] r_x, r_z;
    logic                       take;

    // Take a request when empty or when the held one moves on
    assign o_in_ready = !r_valid || i_advance;
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid;
        if (take)           n_valid = 1'b1;
        else if (i_advance) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold the payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_x <= i_accel_x;
            r_z <= i_accel_z;
        end
    end

    assign o_valid   = r_valid;
    assign o_accel_x = r_x;
    assign o_accel_z = r_z;

endmodule

### hw/rtl/erc_update.sv
// One-sample update of the four repetition recognisers and their counters.
`timescale 1ns / 1ps

module erc_update
    import erc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  t_phases                        i_phases,
    input  logic [3:0][COUNT_BITS-1:0]     i_counts,
    input  logic [3:0]                     i_leds,
    input  logic [TARGET_W-1:0]            i_target,
    input  logic signed [SAMPLE_W-1:0]     i_accel_x,
    input  logic signed [SAMPLE_W-1:0]     i_accel_z,
    output t_phases                        o_phases,
    output logic [3:0][COUNT_BITS-1:0]     o_counts,
    output logic [3:0]                     o_leds
);

    localparam int CMP_W = (COUNT_BITS > TARGET_W) ? COUNT_BITS : TARGET_W;

    logic [CMP_W-1:0] target_ext;

    assign target_ext = CMP_W'(i_target);

    always_comb begin
        t_step st;
        logic  armed;
        logic  jump_nz;

        o_phases = i_phases;
        o_counts = i_counts;
        o_leds   = i_leds;
        jump_nz  = (i_counts[EX_JUMP] != '0);

        // Sit-up: arm on Z, count on X in the same sample
        armed = (i_phases.situp == SU_ARMED) || (i_accel_z >= TH_POS_900);
        if (armed && (i_accel_x >= TH_POS_900)) begin
            o_phases.situp     = SU_IDLE;
            o_counts[EX_SITUP] = o_counts[EX_SITUP] + COUNT_BITS'(1);
            o_leds[EX_SITUP]   = 1'b1;
        end else begin
            o_phases.situp = armed ? SU_ARMED : SU_IDLE;
        end
        if (CMP_W'(o_counts[EX_SITUP]) == target_ext) begin
            o_counts[EX_SITUP] = '0;
            o_leds[EX_SITUP]   = 1'b0;
        end

        // Push-up on Z
        st = three_phase(i_phases.pushup, i_accel_z <= TH_NEG_900,
                         i_accel_z >= TH_NEG_600, i_accel_z <= TH_NEG_1200);
        o_phases.pushup = st.ph;
        if (st.rep) begin
            o_counts[EX_PUSHUP] = o_counts[EX_PUSHUP] + COUNT_BITS'(1);
            o_leds[EX_PUSHUP]   = 1'b1;
        end
        if (CMP_W'(o_counts[EX_PUSHUP]) == target_ext) begin
            o_counts[EX_PUSHUP] = '0;
            o_leds[EX_PUSHUP]   = 1'b0;
        end

        // Squat on X, armed only while no jumps are counted
        st = three_phase(i_phases.squat, !jump_nz && (i_accel_x >= TH_POS_900),
                         i_accel_x <= TH_POS_600, i_accel_x >= TH_POS_1200);
        o_phases.squat = st.ph;
        if (st.rep) begin
            o_counts[EX_SQUAT] = o_counts[EX_SQUAT] + COUNT_BITS'(1);
            o_leds[EX_SQUAT]   = 1'b1;
        end
        if ((CMP_W'(o_counts[EX_SQUAT]) == target_ext) || jump_nz) begin
            o_counts[EX_SQUAT] = '0;
            o_leds[EX_SQUAT]   = 1'b0;
        end

        // Jump on X
        st = three_phase(i_phases.jump, i_accel_x >= TH_POS_1800,
                         i_accel_x <= TH_ZERO, i_accel_x >= TH_POS_900);
        o_phases.jump = st.ph;
        if (st.rep) begin
            o_counts[EX_JUMP] = o_counts[EX_JUMP] + COUNT_BITS'(1);
            o_leds[EX_JUMP]   = 1'b1;
        end
        if (CMP_W'(o_counts[EX_JUMP]) == target_ext) begin
            o_counts[EX_JUMP] = '0;
            o_leds[EX_JUMP]   = 1'b0;
        end
    end

endmodule

### hw/rtl/exercise_rep_counter.sv
// Top level of the exercise repetition counter.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request per X/Z
//   acceleration sample pair in milli-g. Output channel (o_out_valid /
//   i_out_ready) returns one result per request: four indicators and the
//   low 8 bits of the four repetition counts, as they stand after that
//   sample. Results come out in request order.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the target
//   count; it is always ready and should only be written while idle.
// Path: a request that is taken sits in the input register and moves into the
//   result register when the result stage is free.
// Throughput: one request per cycle while i_out_ready stays high; the whole
//   recogniser update is one combinational pass between the input register
//   and the result register.
// Reset: recognisers idle, counts zero, indicators off, target 10, both
//   register stages empty.
// Stall: a result holds while i_out_ready is low; one further request is
//   held in the input register, after which o_in_ready drops.
`timescale 1ns / 1ps

module exercise_rep_counter
    import erc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_accel_x,
    input  logic signed [SAMPLE_W-1:0] i_accel_z,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [TARGET_W-1:0]        i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_situp_led,
    output logic                       o_pushup_led,
    output logic                       o_squat_led,
    output logic                       o_jump_led,
    output logic [REPS_W-1:0]          o_situp_reps,
    output logic [REPS_W-1:0]          o_pushup_reps,
    output logic [REPS_W-1:0]          o_squat_reps,
    output logic [REPS_W-1:0]          o_jump_reps
);

    logic                       s_valid;
    logic signed [SAMPLE_W-1:0] s_x, s_z;
    logic                       advance;

    t_phases                    r_phases, n_phases;
    logic [3:0][COUNT_BITS-1:0] r_counts, n_counts;
    logic [3:0]                 r_leds, n_leds;
    logic [TARGET_W-1:0]        r_target;

    logic                       r_out_valid, n_out_valid;
    logic [3:0]                 r_out_leds;
    logic [3:0][REPS_W-1:0]     r_out_reps;

    // Move the held sample into the result stage when that stage frees up
    assign advance = s_valid && (!r_out_valid || i_out_ready);

    erc_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_accel_x  (i_accel_x),
        .i_accel_z  (i_accel_z),
        .i_advance  (advance),
        .o_valid    (s_valid),
        .o_accel_x  (s_x),
        .o_accel_z  (s_z)
    );

    erc_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .i_phases  (r_phases),
        .i_counts  (r_counts),
        .i_leds    (r_leds),
        .i_target  (r_target),
        .i_accel_x (s_x),
        .i_accel_z (s_z),
        .o_phases  (n_phases),
        .o_counts  (n_counts),
        .o_leds    (n_leds)
    );

    // Target count register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_target <= i_cfg_data;
        end
    end

    // Recogniser state, advanced once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phases <= '{situp: SU_IDLE, pushup: PH_IDLE, squat: PH_IDLE,
                          jump: PH_IDLE};
            r_counts <= '0;
            r_leds   <= '0;
        end else if (advance) begin
            r_phases <= n_phases;
            r_counts <= n_counts;
            r_leds   <= n_leds;
        end
    end

    // Result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (advance)          n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_leds <= n_leds;
            for (int k = 0; k < 4; k++) begin
                r_out_reps[k] <= REPS_W'(n_counts[k]);
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_situp_led   = r_out_leds[EX_SITUP];
    assign o_pushup_led  = r_out_leds[EX_PUSHUP];
    assign o_squat_led   = r_out_leds[EX_SQUAT];
    assign o_jump_led    = r_out_leds[EX_JUMP];
    assign o_situp_reps  = r_out_reps[EX_SITUP];
    assign o_pushup_reps = r_out_reps[EX_PUSHUP];
    assign o_squat_reps  = r_out_reps[EX_SQUAT];
    assign o_jump_reps   = r_out_reps[EX_JUMP];

endmodule

### hw/rtl/erc_checker.sv
// Port-level checks for the exercise repetition counter, bound to the top level.
`timescale 1ns / 1ps

module erc_checker
    import erc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_ready,
    input  logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              o_situp_led,
    input  logic              o_pushup_led,
    input  logic              o_squat_led,
    input  logic              o_jump_led,
    input  logic [REPS_W-1:0] o_situp_reps,
    input  logic [REPS_W-1:0] o_pushup_reps,
    input  logic [REPS_W-1:0] o_squat_reps,
    input  logic [REPS_W-1:0] o_jump_reps
);

    logic [2:0] r_pending, n_pending;
    logic       r_prev_jump_nz;
    logic       in_acc, out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // Track requests taken but not yet answered
    always_comb begin
        n_pending = r_pending;
        if (in_acc && !out_acc)      n_pending = r_pending + 3'd1;
        else if (!in_acc && out_acc) n_pending = r_pending - 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending      <= '0;
            r_prev_jump_nz <= 1'b0;
        end else begin
            r_pending <= n_pending;
            if (out_acc) r_prev_jump_nz <= (o_jump_reps != '0);
        end
    end

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_situp_reps)
            && $stable(o_pushup_reps) && $stable(o_squat_reps)
            && $stable(o_jump_reps) && $stable(o_situp_led)
            && $stable(o_pushup_led) && $stable(o_squat_led)
            && $stable(o_jump_led))
        else $error("stalled result changed");

    // At most two requests in flight, and no result without a request
    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending <= 3'd2) && (!o_out_valid || r_pending != 3'd0))
        else $error("request and result counts disagree");

    // A counted jump before this sample clears the squat count
    a_squat_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_prev_jump_nz |-> o_squat_reps == '0 && !o_squat_led)
        else $error("squat not cleared while jumps counted");

endmodule

bind exercise_rep_counter erc_checker u_erc_checker (.*);
